>>> src/morse_text_to_led_keyer_assert.svh
// assertion macros used by the keyer sequencer
`ifndef MORSE_TEXT_TO_LED_KEYER_ASSERT_SVH
`define MORSE_TEXT_TO_LED_KEYER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define MKEY_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("mkey assertion failed");

// next-cycle implication
`define MKEY_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("mkey assertion failed");

`else

`define MKEY_ASSERT_IMP(label, ck, rn, ante, cons)
`define MKEY_ASSERT_NXT(label, ck, rn, ante, cons)

`endif

`endif

>>> src/mkey_pkg.sv
// shared types, codes and the letter pattern table of the morse keyer
package mkey_pkg;

    localparam int CHAR_W = 8;
    localparam int DOT_W  = 11;
    localparam int PAT_W  = 16;
    localparam int SYM_W  = 2;

    localparam logic [SYM_W-1:0] SYM_NONE = 2'd0;
    localparam logic [SYM_W-1:0] SYM_DOT  = 2'd1;
    localparam logic [SYM_W-1:0] SYM_DASH = 2'd2;
    localparam logic [SYM_W-1:0] SYM_SEP  = 2'd3;

    localparam logic [DOT_W-1:0] DOT_DEFAULT = 11'd200;
    localparam logic [DOT_W-1:0] DOT_MAX     = 11'd2000;

    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_BIT     = 8'h20;

    typedef struct packed {
        logic              led_on;
        logic [SYM_W-1:0]  symbol;
        logic              last_slot;
    } slot_t;

    // international morse words, msb first
    function automatic logic [PAT_W-1:0] letter_pattern(input logic [4:0] idx);
        logic [PAT_W-1:0] p;
        case (idx)
            5'd0:    p = 16'hB800;
            5'd1:    p = 16'hEA80;
            5'd2:    p = 16'hEBA0;
            5'd3:    p = 16'hEA00;
            5'd4:    p = 16'h8000;
            5'd5:    p = 16'hAE80;
            5'd6:    p = 16'hEE80;
            5'd7:    p = 16'hAA00;
            5'd8:    p = 16'hA000;
            5'd9:    p = 16'hBBB8;
            5'd10:   p = 16'hEB80;
            5'd11:   p = 16'hBA80;
            5'd12:   p = 16'hEE00;
            5'd13:   p = 16'hE800;
            5'd14:   p = 16'hEEE0;
            5'd15:   p = 16'hBBA0;
            5'd16:   p = 16'hEEB8;
            5'd17:   p = 16'hBA00;
            5'd18:   p = 16'hA800;
            5'd19:   p = 16'hE000;
            5'd20:   p = 16'hAE00;
            5'd21:   p = 16'hAB80;
            5'd22:   p = 16'hBB80;
            5'd23:   p = 16'hEAE0;
            5'd24:   p = 16'hEBB8;
            5'd25:   p = 16'hEEA0;
            default: p = 16'h0000;
        endcase
        return p;
    endfunction

    function automatic logic [SYM_W-1:0] run_symbol(input logic [1:0] ones);
        logic [SYM_W-1:0] s;
        case (ones)
            2'd1:    s = SYM_DOT;
            2'd3:    s = SYM_DASH;
            default: s = SYM_NONE;
        endcase
        return s;
    endfunction

endpackage

>>> src/mkey_ctrl.sv
// letter decode, gap sequencing and bit-serial pattern shifter
`include "morse_text_to_led_keyer_assert.svh"

module mkey_ctrl
    import mkey_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_tvalid,
    output logic              in_tready,
    input  logic [CHAR_W-1:0] in_char,
    input  logic              in_last,
    output logic              slot_valid,
    input  logic              slot_ready,
    output slot_t             slot
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_GAP  = 2'd1;
    localparam logic [1:0] ST_BITS = 2'd2;

    localparam logic [2:0] GAP_WORD   = 3'd6;
    localparam logic [2:0] GAP_LETTER = 3'd2;

    logic [1:0]       state_reg, state_next;
    logic [PAT_W-1:0] pat_reg, pat_next;
    logic [1:0]       ones_reg, ones_next;
    logic [2:0]       gap_cnt_reg, gap_cnt_next;
    logic             sent_reg, sent_next;
    logic             pend_reg, pend_next;

    logic [CHAR_W-1:0] ch_fold;
    logic [CHAR_W-1:0] ch_off;
    logic              is_alpha;
    logic              is_space;
    logic              accept;

    assign ch_fold   = in_char | CASE_BIT;
    assign ch_off    = ch_fold - CHAR_LOWER_A;
    assign is_alpha  = (ch_fold >= CHAR_LOWER_A) && (ch_fold <= CHAR_LOWER_Z);
    assign is_space  = (in_char == CHAR_SPACE);
    assign in_tready = (state_reg == ST_IDLE);
    assign accept    = in_tvalid && in_tready;

    always_comb
    begin
        state_next   = state_reg;
        pat_next     = pat_reg;
        ones_next    = ones_reg;
        gap_cnt_next = gap_cnt_reg;
        sent_next    = sent_reg;
        pend_next    = pend_reg;
        slot_valid   = 1'b0;
        slot         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_alpha)
                    begin
                        pat_next  = letter_pattern(ch_off[4:0]);
                        ones_next = 2'd0;
                        if (sent_reg)
                        begin
                            gap_cnt_next = pend_reg ? GAP_WORD : GAP_LETTER;
                            state_next   = ST_GAP;
                        end
                        else
                        begin
                            state_next = ST_BITS;
                        end
                        sent_next = !in_last;
                        pend_next = 1'b0;
                    end
                    else if (is_space)
                    begin
                        pend_next = !in_last && (pend_reg || sent_reg);
                        sent_next = !in_last && sent_reg;
                    end
                    else if (in_last)
                    begin
                        sent_next = 1'b0;
                        pend_next = 1'b0;
                    end
                end
            end
            ST_GAP:
            begin
                slot_valid  = 1'b1;
                // separators on the first, second and fifth word-gap slots and the first letter-gap slot
                slot.symbol = (gap_cnt_reg == 3'd6 || gap_cnt_reg == 3'd5 ||
                               gap_cnt_reg == 3'd2) ? SYM_SEP : SYM_NONE;
                if (slot_ready)
                begin
                    gap_cnt_next = gap_cnt_reg - 3'd1;
                    if (gap_cnt_reg == 3'd1)
                    begin
                        state_next = ST_BITS;
                    end
                end
            end
            ST_BITS:
            begin
                slot_valid = 1'b1;
                if (pat_reg != '0)
                begin
                    slot.led_on = pat_reg[PAT_W-1];
                    slot.symbol = pat_reg[PAT_W-1] ? SYM_NONE : run_symbol(ones_reg);
                    if (slot_ready)
                    begin
                        pat_next  = {pat_reg[PAT_W-2:0], 1'b0};
                        ones_next = pat_reg[PAT_W-1] ? ones_reg + 2'd1 : 2'd0;
                    end
                end
                else
                begin
                    // trailing off slot closes the letter
                    slot.symbol    = run_symbol(ones_reg);
                    slot.last_slot = 1'b1;
                    if (slot_ready)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            gap_cnt_reg <= 3'd0;
            sent_reg    <= 1'b0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            gap_cnt_reg <= gap_cnt_next;
            sent_reg    <= sent_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pat_reg  <= pat_next;
        ones_reg <= ones_next;
    end

    `MKEY_ASSERT_IMP(a_gap_cnt_live, clk, rst_n, state_reg == ST_GAP, gap_cnt_reg != 3'd0)
    `MKEY_ASSERT_IMP(a_gap_not_last, clk, rst_n, state_reg == ST_GAP, !slot.last_slot)
    `MKEY_ASSERT_NXT(a_letter_starts, clk, rst_n, accept && is_alpha, state_reg != ST_IDLE)
    `MKEY_ASSERT_NXT(a_last_ends, clk, rst_n, slot_valid && slot_ready && slot.last_slot, state_reg == ST_IDLE)
    `MKEY_ASSERT_NXT(a_sent_after_letter, clk, rst_n, accept && is_alpha && !in_last, sent_reg && !pend_reg)

endmodule

>>> src/mkey_slot_reg.sv
// output register stage for slot beats
module mkey_slot_reg
    import mkey_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             slot_valid,
    output logic             slot_ready,
    input  slot_t            slot,
    input  logic [DOT_W-1:0] hold_time,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [15:0]      m_axis_tdata,
    output logic             m_axis_tlast
);

    logic             valid_reg;
    slot_t            slot_reg;
    logic [DOT_W-1:0] hold_reg;

    assign slot_ready = !valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (slot_ready)
        begin
            valid_reg <= slot_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_ready && slot_valid)
        begin
            slot_reg <= slot;
            hold_reg <= hold_time;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {2'b00, hold_reg, slot_reg.symbol, slot_reg.led_on};
    assign m_axis_tlast  = slot_reg.last_slot;

endmodule

>>> src/morse_text_to_led_keyer.sv
// morse keyer top level: dot-time register, sequencer and output stage
// the first slot beat of a letter passes the sequencer state register and then the output register
// throughput: one slot beat per cycle while m_axis_tready allows; a letter holds the input
// until all its slots are sent, a space or other byte is taken straight from idle
// the pace is set by the single bit-serial pattern shifter in the sequencer
// reset: dot_time 200, letter and word-gap flags clear, no beat pending
module morse_text_to_led_keyer
    import mkey_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,  // [7:0] char_code
    input  logic             s_axis_tlast,  // end_of_write
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // [0] led_on, [2:1] symbol, [13:3] hold_time
    output logic             m_axis_tlast,  // last_slot
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [DOT_W-1:0] cfg_data       // dot_time
);

    logic [DOT_W-1:0] dot_reg;
    logic             slot_valid;
    logic             slot_ready;
    slot_t            slot;

    assign cfg_ready = 1'b1;

    // out-of-range writes fall back to the default
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= DOT_DEFAULT;
        end
        else if (cfg_valid)
        begin
            dot_reg <= (cfg_data == '0 || cfg_data > DOT_MAX) ? DOT_DEFAULT : cfg_data;
        end
    end

    mkey_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_tvalid  (s_axis_tvalid),
        .in_tready  (s_axis_tready),
        .in_char    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .slot_valid (slot_valid),
        .slot_ready (slot_ready),
        .slot       (slot)
    );

    mkey_slot_reg u_slot_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .slot_valid    (slot_valid),
        .slot_ready    (slot_ready),
        .slot          (slot),
        .hold_time     (dot_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
